FILE: hw/rtl/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types and constants of the countdown timer controller.
// ----------------------------------------------------------------------------
package cdt_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_SET_MIN = 3'd1,
      MODE_SET_SEC = 3'd2,
      MODE_COUNT   = 3'd3,
      MODE_BEEP    = 3'd4
   } mode_type;

   localparam logic [2:0]  TENS_MAX     = 3'd5;
   localparam logic [3:0]  ONES_MAX     = 4'd9;
   localparam logic [15:0] IDLE_SAT     = 16'hFFFF;
   localparam logic [15:0] TIMEOUT_RST  = 16'd60;

   typedef struct packed {
      mode_type    mode;
      logic [2:0]  min_tens;
      logic [3:0]  min_ones;
      logic [2:0]  sec_tens;
      logic [3:0]  sec_ones;
      logic [15:0] idle_ticks;
      logic        asleep;
      logic        last_switch;
      logic        last_clk;
   } state_type;

   typedef struct packed {
      logic tick;
      logic switch_level;
      logic encoder_clk;
      logic encoder_dt;
   } sample_type;

endpackage

FILE: hw/rtl/cdt_bcd_field.sv
// ----------------------------------------------------------------------------
// cdt_bcd_field
// Steps a two-digit BCD field up or down, wrapping within 00 to 59.
// ----------------------------------------------------------------------------
module cdt_bcd_field
   import cdt_pkg::*;
(
   input  logic [2:0] tens_i,
   input  logic [3:0] ones_i,
   input  logic       up_i,
   output logic [2:0] tens_o,
   output logic [3:0] ones_o
);

   always_comb begin
      tens_o = tens_i;
      ones_o = ones_i;
      if (up_i) begin
         if (ones_i >= ONES_MAX) begin
            ones_o = 4'd0;
            tens_o = (tens_i >= TENS_MAX) ? 3'd0 : tens_i + 3'd1;
         end else begin
            ones_o = ones_i + 4'd1;
         end
      end else begin
         if (ones_i == 4'd0) begin
            ones_o = ONES_MAX;
            tens_o = (tens_i == 3'd0) ? TENS_MAX : tens_i - 3'd1;
         end else begin
            ones_o = ones_i - 4'd1;
         end
      end
   end

endmodule

FILE: hw/rtl/cdt_next_state.sv
// ----------------------------------------------------------------------------
// cdt_next_state
// Computes the controller state after one sample: button, encoder, tick.
// ----------------------------------------------------------------------------
module cdt_next_state
   import cdt_pkg::*;
(
   input  state_type   cur_i,
   input  sample_type  smp_i,
   input  logic [15:0] timeout_i,
   output state_type   nxt_o
);

   state_type  btn_st;
   logic [2:0] min_tens_step;
   logic [3:0] min_ones_step;
   logic [2:0] sec_tens_step;
   logic [3:0] sec_ones_step;
   logic       time_zero;

   // button step, wake and idle entry
   always_comb begin
      btn_st = cur_i;
      if (cur_i.asleep) begin
         if (smp_i.switch_level != cur_i.last_switch) begin
            btn_st.asleep     = 1'b0;
            btn_st.mode       = MODE_IDLE;
            btn_st.min_tens   = 3'd0;
            btn_st.min_ones   = 4'd0;
            btn_st.sec_tens   = 3'd0;
            btn_st.sec_ones   = 4'd0;
            btn_st.idle_ticks = 16'd0;
         end
      end else if (cur_i.last_switch && !smp_i.switch_level) begin
         unique case (cur_i.mode)
            MODE_IDLE:    btn_st.mode = MODE_SET_MIN;
            MODE_SET_MIN: btn_st.mode = MODE_SET_SEC;
            MODE_SET_SEC: btn_st.mode = MODE_COUNT;
            default: begin
               btn_st.mode       = MODE_IDLE;
               btn_st.min_tens   = 3'd0;
               btn_st.min_ones   = 4'd0;
               btn_st.sec_tens   = 3'd0;
               btn_st.sec_ones   = 4'd0;
               btn_st.idle_ticks = 16'd0;
            end
         endcase
      end
      btn_st.last_switch = smp_i.switch_level;
   end

   cdt_bcd_field u_min_step (
      .tens_i (btn_st.min_tens),
      .ones_i (btn_st.min_ones),
      .up_i   (smp_i.encoder_dt),
      .tens_o (min_tens_step),
      .ones_o (min_ones_step)
   );

   cdt_bcd_field u_sec_step (
      .tens_i (btn_st.sec_tens),
      .ones_i (btn_st.sec_ones),
      .up_i   (smp_i.encoder_dt),
      .tens_o (sec_tens_step),
      .ones_o (sec_ones_step)
   );

   // encoder, tick, zero check
   always_comb begin
      nxt_o = btn_st;
      if (cur_i.last_clk && !smp_i.encoder_clk && !btn_st.asleep) begin
         if (btn_st.mode == MODE_SET_MIN) begin
            nxt_o.min_tens = min_tens_step;
            nxt_o.min_ones = min_ones_step;
         end else if (btn_st.mode == MODE_SET_SEC) begin
            nxt_o.sec_tens = sec_tens_step;
            nxt_o.sec_ones = sec_ones_step;
         end
      end
      nxt_o.last_clk = smp_i.encoder_clk;

      time_zero = (nxt_o.min_tens == 3'd0) && (nxt_o.min_ones == 4'd0) &&
                  (nxt_o.sec_tens == 3'd0) && (nxt_o.sec_ones == 4'd0);

      if (smp_i.tick && !btn_st.asleep) begin
         if (btn_st.mode == MODE_IDLE) begin
            if (nxt_o.idle_ticks != IDLE_SAT) begin
               nxt_o.idle_ticks = nxt_o.idle_ticks + 16'd1;
            end
            if (nxt_o.idle_ticks >= timeout_i) begin
               nxt_o.asleep     = 1'b1;
               nxt_o.idle_ticks = 16'd0;
            end
         end else if (btn_st.mode == MODE_COUNT && !time_zero) begin
            if (nxt_o.sec_ones != 4'd0) begin
               nxt_o.sec_ones = nxt_o.sec_ones - 4'd1;
            end else if (nxt_o.sec_tens != 3'd0) begin
               nxt_o.sec_tens = nxt_o.sec_tens - 3'd1;
               nxt_o.sec_ones = ONES_MAX;
            end else begin
               nxt_o.sec_tens = TENS_MAX;
               nxt_o.sec_ones = ONES_MAX;
               if (nxt_o.min_ones != 4'd0) begin
                  nxt_o.min_ones = nxt_o.min_ones - 4'd1;
               end else begin
                  nxt_o.min_tens = nxt_o.min_tens - 3'd1;
                  nxt_o.min_ones = ONES_MAX;
               end
            end
         end
      end

      if (nxt_o.mode == MODE_COUNT &&
          nxt_o.min_tens == 3'd0 && nxt_o.min_ones == 4'd0 &&
          nxt_o.sec_tens == 3'd0 && nxt_o.sec_ones == 4'd0) begin
         nxt_o.mode = MODE_BEEP;
      end
   end

endmodule

FILE: hw/rtl/mm_ss_countdown_timer_controller_core.sv
// ----------------------------------------------------------------------------
// mm_ss_countdown_timer_controller_core
// Minutes:seconds countdown timer controller with encoder setup and sleep.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one pin sample per transfer (tick, button, encoder clock/data).
//   rsp_*  : one result per sample: mode, four BCD digits, sleep and alarm.
//   csr_*  : write of idle_timeout_seconds; csr_ready is always high, so a
//            write completes in the cycle it is offered. Write while idle.
// Result: a result appears in the result register in the cycle after its
//   sample transfers.
// Throughput: one sample per cycle while req_stall is low. The state update
//   is a single pass of small BCD and mode logic, and the state register
//   feeds the next sample directly, so consecutive samples need no gap.
// Stall: the result register holds a valid result while rsp_stall is high;
//   req_stall rises only while a held result has not yet transferred, so a
//   new sample enters in the same cycle the old result leaves.
// Reset: synchronous, active high. Mode idle, time 00:00, awake, button and
//   encoder clock seen as high, timeout 60 s, result register empty.
// ----------------------------------------------------------------------------
module mm_ss_countdown_timer_controller_core
   import cdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // sample channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_tick,
   input  logic        req_switch_level,
   input  logic        req_encoder_clk,
   input  logic        req_encoder_dt,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_mode,
   output logic [2:0]  rsp_minutes_tens_out,
   output logic [3:0]  rsp_minutes_ones_out,
   output logic [2:0]  rsp_seconds_tens_out,
   output logic [3:0]  rsp_seconds_ones_out,
   output logic        rsp_sleeping,
   output logic        rsp_alarm_active,
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   state_type   state_ff;
   state_type   state_in;
   sample_type  sample;
   logic [15:0] timeout_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   state_type   rsp_ff;
   logic        req_xfer;

   // accept a sample unless a held result is still waiting
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign sample = '{tick:         req_tick,
                     switch_level: req_switch_level,
                     encoder_clk:  req_encoder_clk,
                     encoder_dt:   req_encoder_dt};

   cdt_next_state u_next (
      .cur_i     (state_ff),
      .smp_i     (sample),
      .timeout_i (timeout_ff),
      .nxt_o     (state_in)
   );

   // result valid: load on a sample transfer, drop once the result transfers
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode        <= MODE_IDLE;
         state_ff.min_tens    <= 3'd0;
         state_ff.min_ones    <= 4'd0;
         state_ff.sec_tens    <= 3'd0;
         state_ff.sec_ones    <= 4'd0;
         state_ff.idle_ticks  <= 16'd0;
         state_ff.asleep      <= 1'b0;
         state_ff.last_switch <= 1'b1;
         state_ff.last_clk    <= 1'b1;
         timeout_ff           <= TIMEOUT_RST;
         rsp_valid_ff         <= 1'b0;
      end else begin
         if (req_xfer) begin
            state_ff <= state_in;
         end
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload: advance only on a sample transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_ff <= state_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_mode             = rsp_ff.mode;
   assign rsp_minutes_tens_out = rsp_ff.min_tens;
   assign rsp_minutes_ones_out = rsp_ff.min_ones;
   assign rsp_seconds_tens_out = rsp_ff.sec_tens;
   assign rsp_seconds_ones_out = rsp_ff.sec_ones;
   assign rsp_sleeping         = rsp_ff.asleep;
   assign rsp_alarm_active     = (rsp_ff.mode == MODE_BEEP);

endmodule

FILE: hw/rtl/cdt_checker.sv
// ----------------------------------------------------------------------------
// cdt_checker
// Port-level assertions for the countdown timer controller, bound to the top.
// ----------------------------------------------------------------------------
module cdt_checker
   import cdt_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_mode,
   input logic [2:0] rsp_minutes_tens_out,
   input logic [3:0] rsp_minutes_ones_out,
   input logic [2:0] rsp_seconds_tens_out,
   input logic [3:0] rsp_seconds_ones_out,
   input logic       rsp_sleeping,
   input logic       rsp_alarm_active
);

   // a transferred sample always yields a result in the next cycle
   a_sample_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("sample transfer produced no result");

   // a stalled result stays valid and holds its mode, seconds ones digit and sleep flag
   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_mode) &&
         $stable(rsp_seconds_ones_out) && $stable(rsp_sleeping)))
      else $error("stalled result changed");

   // alarm flag follows the beep mode
   a_alarm_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alarm_active == (rsp_mode == MODE_BEEP)))
      else $error("alarm flag disagrees with mode");

   // sleep only from idle with a cleared time
   a_sleep_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sleeping) |-> (rsp_mode == MODE_IDLE &&
         rsp_minutes_tens_out == 3'd0 && rsp_minutes_ones_out == 4'd0 &&
         rsp_seconds_tens_out == 3'd0 && rsp_seconds_ones_out == 4'd0))
      else $error("asleep outside idle or with nonzero time");

   // digits stay within BCD minutes:seconds range
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_minutes_tens_out <= TENS_MAX &&
         rsp_minutes_ones_out <= ONES_MAX && rsp_seconds_tens_out <= TENS_MAX &&
         rsp_seconds_ones_out <= ONES_MAX))
      else $error("time digit out of range");

endmodule

bind mm_ss_countdown_timer_controller_core cdt_checker u_cdt_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_mode             (rsp_mode),
   .rsp_minutes_tens_out (rsp_minutes_tens_out),
   .rsp_minutes_ones_out (rsp_minutes_ones_out),
   .rsp_seconds_tens_out (rsp_seconds_tens_out),
   .rsp_seconds_ones_out (rsp_seconds_ones_out),
   .rsp_sleeping         (rsp_sleeping),
   .rsp_alarm_active     (rsp_alarm_active)
);
